### rtl/psca_pkg.sv
// Shared types, constants and helpers for the packed saturating counter array.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package psca_pkg;

    // Storage geometry.
    localparam int MAX_ENTRIES = 1024;
    localparam int WORD_BITS   = 32;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int OFS_W       = $clog2(WORD_BITS);

    // Field widths fixed by the interface.
    localparam int OP_W    = 3;
    localparam int INDEX_W = 10;
    localparam int BITS_W  = 6;
    localparam int CNT_W   = 11;
    localparam int POS_W   = INDEX_W + BITS_W;
    localparam int PAIR_W  = 2 * WORD_BITS;
    localparam int SHIFT_W = $clog2(PAIR_W) + 1;

    // Queue between front and back; depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes on the input stream.
    localparam logic [OP_W-1:0] OP_READ  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUT   = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd2;
    localparam logic [OP_W-1:0] OP_SUB   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

    // Configuration register indexes.
    localparam logic REG_BITS_PER_ENTRY = 1'b0;
    localparam logic REG_NUM_ENTRIES    = 1'b1;

    // What the back end has to do with an item.
    typedef enum logic [2:0] {
        KIND_READ,
        KIND_PUT,
        KIND_ADD,
        KIND_SUB,
        KIND_CLEAR,
        KIND_BAD,
        KIND_NONE
    } kind_t;

    // One classified item as it travels through the queue.
    typedef struct packed {
        kind_t                kind;
        logic [ADDR_W-1:0]    word;
        logic [OFS_W-1:0]     offset;
        logic [BITS_W-1:0]    bits;
        logic                 straddle;
        logic [WORD_BITS-1:0] operand;
    } item_t;

    // Status the back end reports to the front end.
    typedef struct packed {
        logic init_busy;
    } back_status_t;

    // Maximum value of a counter of the given width (1 to 32).
    function automatic logic [WORD_BITS-1:0] low_mask(input logic [BITS_W-1:0] bits);
        logic [BITS_W-1:0] drop;
        drop = BITS_W'(WORD_BITS) - bits;
        return {WORD_BITS{1'b1}} >> drop;
    endfunction

endpackage

`default_nettype wire

### rtl/psca_queue.sv
// Short FIFO of classified items between the front and back ends.
// Depends on psca_pkg for the item type and depth.
`default_nettype none

module psca_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  psca_pkg::item_t      push_item,
    input  wire logic            pop,
    output psca_pkg::item_t      head_item,
    output logic                 full,
    output logic                 empty
);

    psca_pkg::item_t                 slot_reg [psca_pkg::QUEUE_DEPTH];
    logic [psca_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [psca_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [psca_pkg::QCNT_W-1:0]     count_reg;
    logic                            do_push;
    logic                            do_pop;

    assign full      = (count_reg == psca_pkg::QCNT_W'(psca_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### rtl/psca_front.sv
// Front end: configuration registers, input acceptance and item classification.
// Depends on psca_pkg for widths, operation codes and the item type.
`default_nettype none

module psca_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [psca_pkg::CNT_W-1:0]  cfg_wdata,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [47:0]                 s_axis_tdata,
    input  wire logic [psca_pkg::OP_W-1:0]   s_axis_tuser,
    input  wire logic                        queue_full,
    input  psca_pkg::back_status_t           back_status,
    output logic                             push,
    output psca_pkg::item_t                  push_item
);

    logic [psca_pkg::BITS_W-1:0]    bits_reg;
    logic [psca_pkg::CNT_W-1:0]     entries_reg;
    logic [psca_pkg::BITS_W-1:0]    eff_bits;
    logic [psca_pkg::CNT_W-1:0]     eff_entries;
    logic [psca_pkg::INDEX_W-1:0]   index;
    logic [psca_pkg::WORD_BITS-1:0] operand;
    logic [psca_pkg::POS_W-1:0]     bit_pos;
    logic [psca_pkg::BITS_W:0]      span_end;
    logic                           bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg    <= psca_pkg::BITS_W'(1);
            entries_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                psca_pkg::REG_BITS_PER_ENTRY: bits_reg    <= cfg_wdata[psca_pkg::BITS_W-1:0];
                psca_pkg::REG_NUM_ENTRIES:    entries_reg <= cfg_wdata;
            endcase
        end
    end

    assign index   = s_axis_tdata[psca_pkg::INDEX_W-1:0];
    assign operand = s_axis_tdata[psca_pkg::INDEX_W +: psca_pkg::WORD_BITS];

    always_comb
    begin
        if (bits_reg == '0)
        begin
            eff_bits = psca_pkg::BITS_W'(1);
        end
        else if (bits_reg > psca_pkg::BITS_W'(psca_pkg::WORD_BITS))
        begin
            eff_bits = psca_pkg::BITS_W'(psca_pkg::WORD_BITS);
        end
        else
        begin
            eff_bits = bits_reg;
        end

        if (entries_reg > psca_pkg::CNT_W'(psca_pkg::MAX_ENTRIES))
        begin
            eff_entries = psca_pkg::CNT_W'(psca_pkg::MAX_ENTRIES);
        end
        else
        begin
            eff_entries = entries_reg;
        end
    end

    // Bit position of the counter, counted from the top bit of word zero.
    assign bit_pos  = psca_pkg::POS_W'(index) * psca_pkg::POS_W'(eff_bits);
    assign span_end = (psca_pkg::BITS_W+1)'(bit_pos[psca_pkg::OFS_W-1:0])
                    + (psca_pkg::BITS_W+1)'(eff_bits);
    assign bad      = ({1'b0, index} >= eff_entries);

    always_comb
    begin
        push_item.word     = bit_pos[psca_pkg::OFS_W +: psca_pkg::ADDR_W];
        push_item.offset   = bit_pos[psca_pkg::OFS_W-1:0];
        push_item.bits     = eff_bits;
        push_item.straddle = (span_end > (psca_pkg::BITS_W+1)'(psca_pkg::WORD_BITS));
        push_item.operand  = operand;
        unique case (s_axis_tuser)
            psca_pkg::OP_READ:  push_item.kind = bad ? psca_pkg::KIND_BAD : psca_pkg::KIND_READ;
            psca_pkg::OP_PUT:   push_item.kind = bad ? psca_pkg::KIND_BAD : psca_pkg::KIND_PUT;
            psca_pkg::OP_ADD:   push_item.kind = bad ? psca_pkg::KIND_BAD : psca_pkg::KIND_ADD;
            psca_pkg::OP_SUB:   push_item.kind = bad ? psca_pkg::KIND_BAD : psca_pkg::KIND_SUB;
            psca_pkg::OP_CLEAR: push_item.kind = psca_pkg::KIND_CLEAR;
            default:            push_item.kind = psca_pkg::KIND_NONE;
        endcase
    end

    assign s_axis_tready = !queue_full && !back_status.init_busy;
    assign push          = s_axis_tvalid && s_axis_tready;

endmodule

`default_nettype wire

### rtl/psca_back.sv
// Back end: counter memory, read-modify-write sequencer, clearing sweep and
// output register. Depends on psca_pkg for the item type and helpers.
`default_nettype none

module psca_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  psca_pkg::item_t                      head_item,
    input  wire logic                            queue_empty,
    output logic                                 pop,
    output psca_pkg::back_status_t               status,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [psca_pkg::WORD_BITS-1:0]       m_axis_tdata,
    output logic [2:0]                           m_axis_tuser
);

    localparam int W  = psca_pkg::WORD_BITS;
    localparam int PW = psca_pkg::PAIR_W;
    localparam int SW = psca_pkg::SHIFT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXTRACT,
        S_CALC,
        S_WRITE_HI,
        S_WRITE_LO,
        S_RESULT
    } state_t;

    state_t                         state_reg;
    logic [psca_pkg::ADDR_W-1:0]    clr_addr_reg;
    logic                           clr_op_reg;
    psca_pkg::item_t                item_reg;
    logic [W-1:0]                   old_reg;
    logic [W-1:0]                   new_reg;
    logic [W-1:0]                   res_value_reg;
    logic                           res_hit_reg;
    logic                           res_zero_reg;
    logic                           res_bad_reg;
    logic                           out_valid_reg;
    logic [W-1:0]                   out_value_reg;
    logic [2:0]                     out_flags_reg;

    logic [W-1:0]                   mem [psca_pkg::MAX_ENTRIES];
    logic [W-1:0]                   hi_word_reg;
    logic [W-1:0]                   lo_word_reg;
    logic                           mem_we;
    logic [psca_pkg::ADDR_W-1:0]    mem_waddr;
    logic [W-1:0]                   mem_wdata;
    logic [psca_pkg::ADDR_W-1:0]    next_word;

    logic [W-1:0]                   max_val;
    logic [SW-1:0]                  shift;
    logic [PW-1:0]                  pair;
    logic [PW-1:0]                  pair_shr;
    logic [W-1:0]                   extracted;
    logic [W-1:0]                   put_val;
    logic [W:0]                     sum;
    logic [W-1:0]                   add_val;
    logic [W-1:0]                   diff;
    logic [PW-1:0]                  field_mask;
    logic [PW-1:0]                  field_data;
    logic [PW-1:0]                  merged;
    logic                           out_free;

    assign next_word = item_reg.word + 1'b1;
    assign max_val   = psca_pkg::low_mask(item_reg.bits);
    assign shift     = SW'(PW) - SW'(item_reg.offset) - SW'(item_reg.bits);
    assign pair      = {hi_word_reg, lo_word_reg};
    assign pair_shr  = pair >> shift;
    assign extracted = pair_shr[W-1:0] & max_val;

    // Candidate new values; only one is used per item.
    assign put_val = (item_reg.operand > max_val) ? max_val : item_reg.operand;
    assign sum     = {1'b0, old_reg} + {1'b0, item_reg.operand};
    assign add_val = (sum > {1'b0, max_val}) ? max_val : sum[W-1:0];
    assign diff    = old_reg - item_reg.operand;

    // Insert the new value into the two-word window.
    assign field_mask = {{W{1'b0}}, max_val} << shift;
    assign field_data = {{W{1'b0}}, new_reg} << shift;
    assign merged     = (pair & ~field_mask) | (field_data & field_mask);

    assign out_free = !out_valid_reg || m_axis_tready;
    assign pop      = (state_reg == S_IDLE) && !queue_empty;
    assign status.init_busy = (state_reg == S_CLEAR) && !clr_op_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = item_reg.word;
        mem_wdata = merged[PW-1:W];
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            S_WRITE_HI:
            begin
                mem_we = 1'b1;
            end
            S_WRITE_LO:
            begin
                mem_we    = 1'b1;
                mem_waddr = next_word;
                mem_wdata = merged[W-1:0];
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_READ)
        begin
            hi_word_reg <= mem[item_reg.word];
            lo_word_reg <= mem[next_word];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            clr_op_reg    <= 1'b0;
            item_reg      <= '0;
            old_reg       <= '0;
            new_reg       <= '0;
            res_value_reg <= '0;
            res_hit_reg   <= 1'b0;
            res_zero_reg  <= 1'b0;
            res_bad_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_flags_reg <= '0;
        end
        else
        begin
            if (state_reg == S_RESULT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == psca_pkg::ADDR_W'(psca_pkg::MAX_ENTRIES - 1))
                    begin
                        state_reg  <= clr_op_reg ? S_RESULT : S_IDLE;
                        clr_op_reg <= 1'b0;
                    end
                end
                S_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        item_reg      <= head_item;
                        res_value_reg <= '0;
                        res_hit_reg   <= 1'b0;
                        res_zero_reg  <= 1'b0;
                        res_bad_reg   <= (head_item.kind == psca_pkg::KIND_BAD);
                        priority if (head_item.kind == psca_pkg::KIND_CLEAR)
                        begin
                            clr_op_reg   <= 1'b1;
                            clr_addr_reg <= '0;
                            state_reg    <= S_CLEAR;
                        end
                        else if (head_item.kind == psca_pkg::KIND_BAD ||
                                 head_item.kind == psca_pkg::KIND_NONE)
                        begin
                            state_reg <= S_RESULT;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EXTRACT;
                end
                S_EXTRACT:
                begin
                    old_reg   <= extracted;
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    unique case (item_reg.kind)
                        psca_pkg::KIND_PUT:
                        begin
                            new_reg       <= put_val;
                            res_value_reg <= put_val;
                            res_hit_reg   <= (put_val == max_val);
                            res_zero_reg  <= (old_reg == '0);
                            state_reg     <= S_WRITE_HI;
                        end
                        psca_pkg::KIND_ADD:
                        begin
                            new_reg       <= add_val;
                            res_value_reg <= add_val;
                            res_hit_reg   <= (add_val == max_val);
                            state_reg     <= S_WRITE_HI;
                        end
                        psca_pkg::KIND_SUB:
                        begin
                            res_value_reg <= old_reg;
                            state_reg     <= S_WRITE_HI;
                            // A saturated counter is sticky and rewritten unchanged.
                            priority if (old_reg == max_val)
                            begin
                                new_reg     <= old_reg;
                                res_hit_reg <= 1'b1;
                            end
                            else if (item_reg.operand > old_reg)
                            begin
                                new_reg     <= '0;
                                res_hit_reg <= 1'b1;
                            end
                            else
                            begin
                                new_reg     <= diff;
                                res_hit_reg <= (diff == max_val);
                            end
                        end
                        default:
                        begin
                            // Reads leave the store alone.
                            res_value_reg <= old_reg;
                            state_reg     <= S_RESULT;
                        end
                    endcase
                end
                S_WRITE_HI:
                begin
                    state_reg <= item_reg.straddle ? S_WRITE_LO : S_RESULT;
                end
                S_WRITE_LO:
                begin
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (out_free)
                    begin
                        out_value_reg <= res_value_reg;
                        out_flags_reg <= {res_bad_reg, res_zero_reg, res_hit_reg};
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_flags_reg;

endmodule

`default_nettype wire

### rtl/packed_saturating_counter_array_unit.sv
// A read steps through the read, extract, calc and result states; a put, add or subtract
// also writes the upper word, and the lower word if the counter straddles two words;
// a bad index or unknown op goes straight to the result state. The single
// read-modify-write sequencer takes one item at a time; a clear sweeps all words. Reset:
// asynchronous, active low; then a pass over all MAX_ENTRIES (1024) words
// zeroes the memory while s_axis_tready stays low. Configuration writes are taken always.
`default_nettype none

module packed_saturating_counter_array_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,

    // Configuration: index 0 is bits_per_entry, index 1 is num_entries.
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [10:0]  cfg_wdata,

    // Input stream.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [47:0]  s_axis_tdata,   // index [9:0], operand [41:10], zero pad
    input  wire logic [2:0]   s_axis_tuser,   // op [2:0]

    // Result stream.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // value [31:0]
    output logic [2:0]        m_axis_tuser    // hit_limit [0], was_zero [1], bad_index [2]
);

    // The front end checks the index against the configured count, works out
    // where the counter sits in the packed words and whether it straddles a
    // word boundary, and queues the classified item.
    psca_pkg::item_t        push_item;
    psca_pkg::item_t        head_item;
    psca_pkg::back_status_t back_status;
    logic                   push;
    logic                   pop;
    logic                   queue_full;
    logic                   queue_empty;

    psca_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .back_status   (back_status),
        .push          (push),
        .push_item     (push_item)
    );

    // The queue lets the front keep accepting while the back end is busy, until it is full.
    psca_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // The back end reads the word holding the counter and the word after it, extracts
    // the counter, applies the operation, merges the new value back and writes the one
    // or two words, then loads the result into the output register. The output
    // register lets the next item start while a result waits to be taken.
    psca_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_item     (head_item),
        .queue_empty   (queue_empty),
        .pop           (pop),
        .status        (back_status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
